/* rtl/amfi_pkg.sv */
// shared types, constants and header tables of the avi mjpeg frame indexer
package amfi_pkg;

  localparam int unsigned POS_W     = 25;
  localparam int unsigned OFFSET_W  = 24;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned CFG_W     = 25;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [POS_W-1:0]   STREAM_BYTES_MAX = 25'd16777216;
  localparam logic [COUNT_W-1:0] FRAMES_MAX       = 16'd65535;
  localparam logic [POS_W-1:0]   POS_SAT          = 25'h1FFFFFF;
  localparam logic [POS_W-1:0]   SCAN_START       = 25'd12;
  localparam logic [POS_W-1:0]   HEADER_LAST      = 25'd11;
  localparam logic [POS_W-1:0]   RIFF_END         = 25'd4;
  localparam logic [POS_W-1:0]   AVI_START        = 25'd8;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_STREAM_BYTES = 2'd0,
    CFG_MAX_FRAMES       = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_TOO_MANY  = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef enum logic {
    REC_FRAME  = 1'b0,
    REC_STATUS = 1'b1
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t             record_kind;
    logic [COUNT_W-1:0]    frame_number;
    logic [OFFSET_W-1:0]   frame_offset;
    logic [OFFSET_W-1:0]   frame_length;
    status_t               stream_status;
    logic [COUNT_W-1:0]    frames_total;
    logic                  run_end;
  } result_t;

  function automatic logic [7:0] riff_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h52;
      2'd1: c = 8'h49;
      2'd2: c = 8'h46;
      2'd3: c = 8'h46;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] avi_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h41;
      2'd1: c = 8'h56;
      2'd2: c = 8'h49;
      2'd3: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/amfi_scan.sv */
// byte scanner: header check, marker search, frame counting and error keeping
module amfi_scan import amfi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic [1:0]           push_num,
  output result_t              push_rec0,
  output result_t              push_rec1
);

  logic [POS_W-1:0]    max_stream_bytes;
  logic [COUNT_W-1:0]  max_frames;

  logic [POS_W-1:0]    byte_position;
  logic                previous_was_ff;
  logic                inside_frame;
  logic [OFFSET_W-1:0] frame_start_offset;
  logic [COUNT_W-1:0]  frames_found;
  logic                header_matches;
  status_t             first_error;

  logic [POS_W-1:0]    byte_position_next;
  logic                previous_was_ff_next;
  logic                inside_frame_next;
  logic [OFFSET_W-1:0] frame_start_offset_next;
  logic [COUNT_W-1:0]  frames_found_next;
  logic                header_matches_next;
  status_t             first_error_next;

  logic [POS_W-1:0]    limit;
  logic [COUNT_W-1:0]  capacity;
  logic                hdr_bad;
  logic                frame_emit;
  result_t             frame_rec;
  result_t             status_rec;

  // effective limits
  always_comb begin
    limit    = (max_stream_bytes > STREAM_BYTES_MAX) ? STREAM_BYTES_MAX : max_stream_bytes;
    capacity = (max_frames > FRAMES_MAX) ? FRAMES_MAX : max_frames;
  end

  always_comb begin
    byte_position_next      = byte_position;
    previous_was_ff_next    = previous_was_ff;
    inside_frame_next       = inside_frame;
    frame_start_offset_next = frame_start_offset;
    frames_found_next       = frames_found;
    header_matches_next     = header_matches;
    first_error_next        = first_error;
    hdr_bad                 = 1'b0;
    frame_emit              = 1'b0;

    frame_rec               = '0;
    frame_rec.record_kind   = REC_FRAME;
    frame_rec.stream_status = ST_OK;
    frame_rec.frame_number  = frames_found;
    frame_rec.frame_offset  = frame_start_offset;
    frame_rec.frame_length  = byte_position[OFFSET_W-1:0] + 24'd1 - frame_start_offset;

    if (first_error == ST_OK && byte_position >= limit) begin
      first_error_next = ST_TOO_LONG;
    end

    if (first_error_next == ST_OK) begin
      if (byte_position < SCAN_START) begin
        if (byte_position < RIFF_END && data_byte != riff_char(byte_position[1:0])) begin
          hdr_bad = 1'b1;
        end
        if (byte_position >= AVI_START && data_byte != avi_char(byte_position[1:0])) begin
          hdr_bad = 1'b1;
        end
        if (hdr_bad) begin
          header_matches_next = 1'b0;
          first_error_next    = ST_BAD_HDR;
        end
      end else if (!inside_frame) begin
        if (previous_was_ff && data_byte == MARK_SOI) begin
          inside_frame_next       = 1'b1;
          frame_start_offset_next = byte_position[OFFSET_W-1:0] - 24'd1;
          previous_was_ff_next    = 1'b0;
        end else begin
          previous_was_ff_next = (data_byte == MARK_PREFIX);
        end
      end else begin
        if (previous_was_ff && data_byte == MARK_EOI) begin
          inside_frame_next    = 1'b0;
          previous_was_ff_next = 1'b0;
          if (frames_found >= capacity) begin
            first_error_next = ST_TOO_MANY;
          end else begin
            frame_emit        = 1'b1;
            frames_found_next = frames_found + 16'd1;
          end
        end else begin
          previous_was_ff_next = (data_byte == MARK_PREFIX);
        end
      end
    end

    if (byte_position != POS_SAT) begin
      byte_position_next = byte_position + 25'd1;
    end

    if (last_byte && first_error_next == ST_OK) begin
      priority if (byte_position < HEADER_LAST || !header_matches_next) begin
        first_error_next = ST_BAD_HDR;
      end else if (inside_frame_next) begin
        first_error_next = ST_TRUNCATED;
      end else if (frames_found_next == '0) begin
        first_error_next = ST_NONE;
      end else begin
        first_error_next = ST_OK;
      end
    end

    status_rec               = '0;
    status_rec.record_kind   = REC_STATUS;
    status_rec.stream_status = first_error_next;
    status_rec.frames_total  = frames_found_next;
    status_rec.run_end       = 1'b1;

    frame_rec.run_end = !last_byte;

    if (last_byte) begin
      byte_position_next      = '0;
      previous_was_ff_next    = 1'b0;
      inside_frame_next       = 1'b0;
      frame_start_offset_next = '0;
      frames_found_next       = '0;
      header_matches_next     = 1'b1;
      first_error_next        = ST_OK;
    end

    push_num  = step ? ({1'b0, frame_emit} + {1'b0, last_byte}) : 2'd0;
    push_rec0 = frame_emit ? frame_rec : status_rec;
    push_rec1 = status_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_stream_bytes <= STREAM_BYTES_MAX;
      max_frames       <= 16'hFFFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAX_STREAM_BYTES: max_stream_bytes <= cfg_data;
        CFG_MAX_FRAMES:       max_frames       <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      previous_was_ff    <= 1'b0;
      inside_frame       <= 1'b0;
      frame_start_offset <= '0;
      frames_found       <= '0;
      header_matches     <= 1'b1;
      first_error        <= ST_OK;
    end else if (step) begin
      byte_position      <= byte_position_next;
      previous_was_ff    <= previous_was_ff_next;
      inside_frame       <= inside_frame_next;
      frame_start_offset <= frame_start_offset_next;
      frames_found       <= frames_found_next;
      header_matches     <= header_matches_next;
      first_error        <= first_error_next;
    end
  end

  // end of stream re-arms the scanner
  assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> byte_position == '0 && frames_found == '0 && first_error == ST_OK)
    else $error("scanner not re-armed after last item");

  // a kept error holds until the stream ends
  assert property (@(posedge clk) disable iff (rst)
    first_error != ST_OK && !(step && last_byte) |=> first_error == $past(first_error))
    else $error("kept error changed mid-stream");

  // no frame record once an error is kept
  assert property (@(posedge clk) disable iff (rst)
    step && frame_emit |-> first_error == ST_OK)
    else $error("frame record after error");

endmodule

/* rtl/amfi_result_fifo.sv */
// four-entry result queue, up to two pushes and one pop per cycle
module amfi_result_fifo import amfi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_num,
  input  result_t               push_rec0,
  input  result_t               push_rec1,
  input  logic                  pop,
  output result_t               head,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W-1:0] wr_ptr_p1;
  logic                  pop_ok;

  assign wr_ptr_p1 = wr_ptr + 2'd1;
  assign pop_ok    = pop && count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      entries[wr_ptr] <= push_rec0;
    end
    if (push_num == 2'd2) begin
      entries[wr_ptr_p1] <= push_rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_num);
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + FIFO_CNT_W'(push_num) - FIFO_CNT_W'(pop_ok);
    end
  end

endmodule

/* rtl/avi_mjpeg_frame_indexer.sv */
// top level of the avi mjpeg frame indexer: input register, scanner, result queue
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------------
//   in      | in_valid / in_ready      | data_byte, last_byte
//   out     | out_valid / out_ready    | record_kind .. run_end, one port each
//   cfg     | cfg_write                | cfg_index, cfg_data
//
// one byte per cycle sustained while out_ready is high; a byte waits in the input
// register until it is scanned, and its results show on out the cycle after that
// a stream's last byte gives up to two results, drained one per out_ready cycle
// a byte is scanned only when the four-entry result queue has two free slots
// rst is synchronous and clears control state and both registers to reset values
module avi_mjpeg_frame_indexer import amfi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 record_kind,
  output logic [COUNT_W-1:0]   frame_number,
  output logic [OFFSET_W-1:0]  frame_offset,
  output logic [OFFSET_W-1:0]  frame_length,
  output logic [2:0]           stream_status,
  output logic [COUNT_W-1:0]   frames_total,
  output logic                 run_end
);

  logic                  buf_valid;
  logic [7:0]            buf_byte;
  logic                  buf_last;
  logic                  step;
  logic                  room;
  logic [1:0]            push_num;
  result_t               push_rec0;
  result_t               push_rec1;
  result_t               head;
  logic [FIFO_CNT_W-1:0] count;

  assign room     = count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign step     = buf_valid && room;
  assign in_ready = !buf_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      buf_valid <= 1'b1;
    end else if (step) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_byte <= data_byte;
      buf_last <= last_byte;
    end
  end

  amfi_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .data_byte (buf_byte),
    .last_byte (buf_last),
    .push_num  (push_num),
    .push_rec0 (push_rec0),
    .push_rec1 (push_rec1)
  );

  amfi_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_num  (push_num),
    .push_rec0 (push_rec0),
    .push_rec1 (push_rec1),
    .pop       (out_ready),
    .head      (head),
    .count     (count)
  );

  assign out_valid     = count != '0;
  assign record_kind   = head.record_kind;
  assign frame_number  = head.frame_number;
  assign frame_offset  = head.frame_offset;
  assign frame_length  = head.frame_length;
  assign stream_status = head.stream_status;
  assign frames_total  = head.frames_total;
  assign run_end       = head.run_end;

endmodule
